[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files of the float packer.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/fpk_pkg.sv]
// Package for the float packer: status codes, widths and helper types.
// Depends on nothing.
`default_nettype none
package fpk_pkg;
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_RANGE = 2'd1,
		ST_INFNAN = 2'd2,
		ST_BADW = 2'd3
	} status_t;

	localparam int TB_W = 7;
	localparam int EB_W = 4;
	localparam logic [TB_W-1:0] TB_RESET = 7'd32;
	localparam logic [EB_W-1:0] EB_RESET = 4'd8;
	localparam logic [6:0] HALF_MAX_F = 7'd22;
	localparam logic [0:0] IDX_TOTAL = 1'b0;
	localparam logic [0:0] IDX_EXP = 1'b1;

	// Decoded input held in the first pipeline stage.
	typedef struct packed {
		logic bad_w;
		logic inf_nan;
		logic zero;
		logic sign;
		logic signed [12:0] e;
		logic [51:0] frac;
		logic [5:0] f;
		logic [6:0] tb;
		logic [3:0] eb;
	} dec_t;
endpackage
`default_nettype wire

[rtl/core/fpk_decode.sv]
// Input decode stage: unpacks binary64, normalizes subnormals, checks widths.
// Depends on fpk_pkg.
`default_nettype none
module fpk_decode (
	input wire logic [63:0] value_bits,
	input wire logic [6:0] tb,
	input wire logic [3:0] eb,
	output fpk_pkg::dec_t dec
);
	logic [10:0] bexp;
	logic [51:0] mant;
	logic [5:0] p;
	logic found;
	logic [6:0] f7;

	assign bexp = value_bits[62:52];
	assign mant = value_bits[51:0];

	// Leading-one position of the subnormal mantissa (0 when none above bit 0).
	always_comb begin
		p = 6'd0;
		found = 1'b0;
		for (int i = 51; i > 0; i--) begin
			if (!found && mant[i]) begin
				p = 6'(i);
				found = 1'b1;
			end
		end
	end

	assign f7 = tb - 7'(eb) - 7'd1;

	always_comb begin
		dec.bad_w = (tb < 7'd2) || (tb > 7'd64) || (eb < 4'd1) || (eb > 4'd11)
			|| (7'(eb) + 7'd1 > tb);
		dec.inf_nan = (bexp == 11'h7FF);
		dec.zero = (bexp == 11'd0) && (mant == 52'd0);
		dec.sign = value_bits[63];
		dec.f = f7[5:0];
		dec.tb = tb;
		dec.eb = eb;
		if (bexp == 11'd0) begin
			dec.e = 13'(p) - 13'sd1074;
			dec.frac = mant << (6'd52 - p);
		end else begin
			dec.e = $signed({2'b00, bexp}) - 13'sd1023;
			dec.frac = mant;
		end
	end
endmodule
`default_nettype wire

[rtl/core/fpk_pack.sv]
// Pack stage: scales the fraction, biases the exponent, forms the word.
// Depends on fpk_pkg.
`default_nettype none
module fpk_pack (
	input wire fpk_pkg::dec_t dec,
	output logic [63:0] packed_word,
	output fpk_pkg::status_t st
);
	logic [5:0] lo_bits;
	logic [51:0] q;
	logic [51:0] r;
	logic [115:0] tail;
	logic [63:0] sig;
	logic signed [12:0] bias;
	logic signed [12:0] exmax;
	logic signed [12:0] ex;
	logic [63:0] ex64;

	// Fraction scale: 2^f + 1/2 up to f of 22, plain 2^f above.
	always_comb begin
		lo_bits = 6'd52 - dec.f;
		q = dec.frac >> lo_bits;
		r = dec.frac & ~(52'hF_FFFF_FFFF_FFFF << lo_bits);
		tail = (116'(r) << (dec.f + 6'd1)) + 116'(dec.frac);
		if (7'(dec.f) <= fpk_pkg::HALF_MAX_F)
			sig = 64'(q) + 64'(tail >> 53);
		else if (dec.f >= 6'd52)
			sig = 64'(dec.frac) << (dec.f - 6'd52);
		else
			sig = 64'(dec.frac >> (6'd52 - dec.f));
	end

	// Exponent bias and range.
	always_comb begin
		bias = 13'sd1 <<< (dec.eb - 4'd1);
		bias = bias - 13'sd1;
		exmax = (13'sd1 <<< dec.eb) - 13'sd1;
		ex = dec.e + bias;
		ex64 = 64'(signed'(ex));
	end

	// Result word and status with bad widths first.
	always_comb begin
		packed_word = 64'd0;
		st = fpk_pkg::ST_OK;
		if (dec.bad_w) begin
			st = fpk_pkg::ST_BADW;
		end else if (dec.inf_nan) begin
			st = fpk_pkg::ST_INFNAN;
		end else if (!dec.zero) begin
			packed_word = (64'(dec.sign) << (dec.tb - 7'd1)) | (ex64 << dec.f) | sig;
			if (ex < 13'sd0 || ex > exmax)
				st = fpk_pkg::ST_RANGE;
		end
	end
endmodule
`default_nettype wire

[rtl/core/float_pack_custom_format.sv]
// Top level of the float packer: config registers, two pipeline stages.
// Depends on fpk_pkg, fpk_decode, fpk_pack and assert_macros.svh.
// Takes one binary64 value per cycle when start is high and busy is low;
// busy is always low. Each result passes through the decode stage register
// and then the result register after the pack stage, and is driven with done
// high for exactly one cycle.
// The receiver cannot stall, so results must be taken when done is high.
`default_nettype none
`include "assert_macros.svh"
module float_pack_custom_format (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [63:0] value_bits,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_idx,
	input wire logic [6:0] cfg_wdata,
	output logic done,
	output logic [63:0] packed_res,
	output logic [1:0] status
);
	logic [6:0] tb_q;
	logic [3:0] eb_q;
	logic v_s1, v_s2;
	fpk_pkg::dec_t dec_d, dec_s1;
	logic [63:0] word_d;
	fpk_pkg::status_t st_d;

	assign busy = 1'b0;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= fpk_pkg::TB_RESET;
			eb_q <= fpk_pkg::EB_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == fpk_pkg::IDX_TOTAL)
				tb_q <= cfg_wdata;
			else if (cfg_idx == fpk_pkg::IDX_EXP)
				eb_q <= cfg_wdata[3:0];
		end
	end

	fpk_decode u_dec (.value_bits(value_bits), .tb(tb_q), .eb(eb_q), .dec(dec_d));

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// Decoded item register.
	always_ff @(posedge clk) begin
		dec_s1 <= dec_d;
	end

	fpk_pack u_pack (.dec(dec_s1), .packed_word(word_d), .st(st_d));

	// Result register.
	always_ff @(posedge clk) begin
		packed_res <= word_d;
		status <= st_d;
	end

	assign done = v_s2;

	`ASSERT_NEXT(a_done_follows, v_s1, done, "done missing after stage one")
	`ASSERT_CLK(a_never_busy, !busy, "busy raised")
	`ASSERT_NEXT(a_zero_on_fault, v_s1 && (dec_s1.bad_w || dec_s1.inf_nan),
		packed_res == 64'd0, "nonzero word on fault")
endmodule
`default_nettype wire
